### design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, constants and helpers for the text console character writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STOP   = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int COLX_W = $clog2(COLUMNS + TAB_STOP + 1);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ROWX_W = $clog2(ROWS + 1);
  localparam int CELL_W = $clog2(CELL_COUNT);
  localparam int TAB_COUNT = (COLUMNS + TAB_STOP - 1) / TAB_STOP;

  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int LOC_W   = 11;
  localparam int CELLD_W = 16;
  localparam int COLOR_W = 4;
  localparam int ATTR_W  = 8;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0]  CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0]  CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0]  CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0]  CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0]  CH_SPACE = 8'h20;
  localparam logic [CELLD_W-1:0] SCROLL_BLANK = 16'h0F20;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'd2;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd6;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_SPARE = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FG = 1'b0,
    REG_BG = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_PRINT,
    K_BS,
    K_TAB,
    K_CR,
    K_LF,
    K_CLEAR,
    K_READ
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
    logic [CELL_W-1:0] cell_idx;
  } q_entry_t;

  // next tab stop after column col
  function automatic logic [COLX_W-1:0] tab_next(input logic [COL_W-1:0] col);
    logic [COLX_W-1:0] r;
    r = COLX_W'(TAB_STOP);
    for (int k = 1; k < TAB_COUNT; k++) begin
      if (int'(col) >= k * TAB_STOP) begin
        r = COLX_W'((k + 1) * TAB_STOP);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Input side: accepts command transactions and classifies them for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front (
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [tcw_pkg::IN_DATA_W-1:0]     in_tdata,  // char_code, cell_index
  input  wire logic [tcw_pkg::CMD_W-1:0]         in_tuser,  // cmd
  input  wire logic                              init_done,
  input  wire logic                              q_ready,
  output logic                                   q_push,
  output tcw_pkg::q_entry_t                      q_entry
);

  logic [tcw_pkg::CHAR_W-1:0]  ch;
  logic [tcw_pkg::INDEX_W-1:0] idx;
  tcw_pkg::cmd_t               cmd;

  assign ch  = in_tdata[tcw_pkg::CHAR_W-1:0];
  assign idx = in_tdata[tcw_pkg::CHAR_W +: tcw_pkg::INDEX_W];
  assign cmd = tcw_pkg::cmd_t'(in_tuser);

  assign in_tready = q_ready && init_done;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_entry.ch       = ch;
    q_entry.cell_idx = tcw_pkg::CELL_W'(idx);
    q_entry.kind     = tcw_pkg::K_NONE;
    case (cmd)
      tcw_pkg::CMD_PUT: begin
        if (ch == tcw_pkg::CH_BS) begin
          q_entry.kind = tcw_pkg::K_BS;
        end else if (ch == tcw_pkg::CH_TAB) begin
          q_entry.kind = tcw_pkg::K_TAB;
        end else if (ch == tcw_pkg::CH_CR) begin
          q_entry.kind = tcw_pkg::K_CR;
        end else if (ch == tcw_pkg::CH_LF) begin
          q_entry.kind = tcw_pkg::K_LF;
        end else if (!ch[tcw_pkg::CHAR_W-1] && ch >= tcw_pkg::CH_SPACE) begin
          q_entry.kind = tcw_pkg::K_PRINT;
        end
      end
      tcw_pkg::CMD_CLEAR: q_entry.kind = tcw_pkg::K_CLEAR;
      tcw_pkg::CMD_READ: begin
        // out-of-range reads behave as no-ops returning 0
        if (int'(idx) < tcw_pkg::CELL_COUNT) begin
          q_entry.kind = tcw_pkg::K_READ;
        end
      end
      default: q_entry.kind = tcw_pkg::K_NONE;
    endcase
  end

endmodule

`default_nettype wire

### design/tcw_cmd_queue.sv
// ----------------------------------------------------------------------------
// tcw_cmd_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cmd_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire tcw_pkg::q_entry_t push_entry,
  output logic                   ready,
  input  wire logic              pop,
  output tcw_pkg::q_entry_t      head,
  output logic                   valid
);

  tcw_pkg::q_entry_t           entries_r [tcw_pkg::QDEPTH];
  logic [tcw_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [tcw_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [tcw_pkg::QCNT_W-1:0]  count_r;

  assign ready = (int'(count_r) < tcw_pkg::QDEPTH);
  assign valid = (count_r != '0);
  assign head  = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (int'(wr_ptr_r) == tcw_pkg::QDEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (int'(rd_ptr_r) == tcw_pkg::QDEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Execution side: cell store, cursor, clear and scroll sweeps, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [tcw_pkg::ATTR_W-1:0]         attr,
  input  wire logic                               q_valid,
  input  wire tcw_pkg::q_entry_t                  q_head,
  output logic                                    q_pop,
  output logic                                    init_done,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [tcw_pkg::OUT_DATA_W-1:0]          out_tdata  // cursor_location, read_data
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_SCR_BLK,
    ST_RD_WAIT,
    ST_RESP
  } state_t;

  localparam logic [tcw_pkg::CELL_W-1:0] LAST_CELL  = tcw_pkg::CELL_W'(tcw_pkg::CELL_COUNT - 1);
  localparam logic [tcw_pkg::CELL_W-1:0] LAST_MOVE  =
    tcw_pkg::CELL_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS - 1);
  localparam logic [tcw_pkg::CELL_W-1:0] FIRST_BLK  =
    tcw_pkg::CELL_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
  localparam logic [tcw_pkg::CELL_W-1:0] ROW_STRIDE = tcw_pkg::CELL_W'(tcw_pkg::COLUMNS);

  state_t                          state_r, state_nxt;
  logic [tcw_pkg::COL_W-1:0]       col_r, col_nxt;
  logic [tcw_pkg::ROW_W-1:0]       row_r, row_nxt;
  logic [tcw_pkg::CELL_W-1:0]      ptr_r, ptr_nxt;
  logic [tcw_pkg::CELLD_W-1:0]     rdata_r, rdata_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [tcw_pkg::OUT_DATA_W-1:0]  odata_r, odata_nxt;

  logic [tcw_pkg::CELLD_W-1:0]     cells [tcw_pkg::CELL_COUNT];
  logic [tcw_pkg::CELLD_W-1:0]     mem_rd_q;
  logic                            mem_we;
  logic [tcw_pkg::CELL_W-1:0]      mem_addr;
  logic [tcw_pkg::CELLD_W-1:0]     mem_wdata;

  logic [tcw_pkg::COLX_W-1:0]      colx;
  logic [tcw_pkg::ROWX_W-1:0]      rowx;
  logic                            scroll;
  logic [tcw_pkg::CELL_W-1:0]      cur_idx;
  logic [tcw_pkg::LOC_W-1:0]       loc;

  assign init_done  = (state_r != ST_INIT);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = odata_r;

  assign cur_idx = tcw_pkg::CELL_W'(int'(row_r) * tcw_pkg::COLUMNS + int'(col_r));
  assign loc     = tcw_pkg::LOC_W'(int'(row_r) * tcw_pkg::COLUMNS + int'(col_r));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells[mem_addr] <= mem_wdata;
    end
    mem_rd_q <= cells[mem_addr];
  end

  // cursor movement for put commands
  always_comb begin
    colx = tcw_pkg::COLX_W'(col_r);
    rowx = tcw_pkg::ROWX_W'(row_r);
    case (q_head.kind)
      tcw_pkg::K_BS: begin
        if (col_r != '0) begin
          colx = tcw_pkg::COLX_W'(col_r) - 1'b1;
        end
      end
      tcw_pkg::K_TAB:   colx = tcw_pkg::tab_next(col_r);
      tcw_pkg::K_CR:    colx = '0;
      tcw_pkg::K_LF: begin
        colx = '0;
        rowx = tcw_pkg::ROWX_W'(row_r) + 1'b1;
      end
      tcw_pkg::K_PRINT: colx = tcw_pkg::COLX_W'(col_r) + 1'b1;
      default:          colx = tcw_pkg::COLX_W'(col_r);
    endcase
    if (int'(colx) >= tcw_pkg::COLUMNS) begin
      colx = '0;
      rowx = rowx + 1'b1;
    end
    scroll = (int'(rowx) >= tcw_pkg::ROWS);
  end

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    ptr_nxt       = ptr_r;
    rdata_nxt     = rdata_r;
    out_valid_nxt = out_valid_r && !out_tready;
    odata_nxt     = odata_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = ptr_r;
    mem_wdata     = '0;
    case (state_r)
      ST_INIT: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST_CELL) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          rdata_nxt = '0;
          case (q_head.kind)
            tcw_pkg::K_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              ptr_nxt   = '0;
              state_nxt = ST_FILL;
            end
            tcw_pkg::K_READ: begin
              mem_addr  = q_head.cell_idx;
              state_nxt = ST_RD_WAIT;
            end
            tcw_pkg::K_NONE: state_nxt = ST_RESP;
            default: begin
              if (q_head.kind == tcw_pkg::K_PRINT) begin
                mem_we    = 1'b1;
                mem_addr  = cur_idx;
                mem_wdata = {attr, q_head.ch};
              end
              col_nxt = tcw_pkg::COL_W'(colx);
              if (scroll) begin
                row_nxt   = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
                ptr_nxt   = '0;
                state_nxt = ST_SCR_RD;
              end else begin
                row_nxt   = tcw_pkg::ROW_W'(rowx);
                state_nxt = ST_RESP;
              end
            end
          endcase
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = {attr, tcw_pkg::CH_SPACE};
        ptr_nxt   = ptr_r + 1'b1;
        if (ptr_r == LAST_CELL) begin
          state_nxt = ST_RESP;
        end
      end
      ST_SCR_RD: begin
        mem_addr  = ptr_r + ROW_STRIDE;
        state_nxt = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rd_q;
        if (ptr_r == LAST_MOVE) begin
          ptr_nxt   = FIRST_BLK;
          state_nxt = ST_SCR_BLK;
        end else begin
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = ST_SCR_RD;
        end
      end
      ST_SCR_BLK: begin
        mem_we    = 1'b1;
        mem_wdata = tcw_pkg::SCROLL_BLANK;
        ptr_nxt   = ptr_r + 1'b1;
        if (ptr_r == LAST_CELL) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RD_WAIT: begin
        rdata_nxt = mem_rd_q;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          odata_nxt     = tcw_pkg::OUT_DATA_W'({rdata_r, loc});
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      col_r       <= '0;
      row_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rdata_r <= rdata_nxt;
    odata_r <= odata_nxt;
  end

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(col_r) < tcw_pkg::COLUMNS) && (int'(row_r) < tcw_pkg::ROWS))
    else $error("cursor outside the screen");

  a_scroll_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCR_WR) |-> $past(state_r == ST_SCR_RD))
    else $error("scroll write without preceding read");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && out_valid_r && !out_tready) |=> (state_r == ST_RESP))
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire

### design/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text console engine with an 80x25 cell store and cursor.
// ----------------------------------------------------------------------------
// Each command transaction gives exactly one result transaction carrying the
// cursor location and, for a read, the cell contents. All cell traffic goes
// through one single-port cell memory, so a clear sweeps every cell in turn
// and a put that scrolls moves each cell up a row with a read state and then
// a write state per cell, then blanks the last row. After reset a clearing
// pass zeroes the store, with in_tready held low; colour writes are taken
// during it. A two-entry command queue lets new commands be taken while one
// executes and while a result waits on out_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [tcw_pkg::IN_DATA_W-1:0]     in_tdata,   // char_code, cell_index
  input  wire logic [tcw_pkg::CMD_W-1:0]         in_tuser,   // cmd
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [tcw_pkg::OUT_DATA_W-1:0]         out_tdata,  // cursor_location, read_data
  input  wire logic                              cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tcw_pkg::COLOR_W-1:0]       cfg_wdata
);

  logic [tcw_pkg::COLOR_W-1:0] fg_r;
  logic [tcw_pkg::COLOR_W-1:0] bg_r;
  logic                        init_done;
  logic                        q_ready;
  logic                        q_push;
  logic                        q_pop;
  logic                        q_valid;
  tcw_pkg::q_entry_t           q_in;
  tcw_pkg::q_entry_t           q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= tcw_pkg::FG_RESET;
      bg_r <= tcw_pkg::BG_RESET;
    end else if (cfg_we) begin
      case (tcw_pkg::reg_idx_t'(cfg_index))
        tcw_pkg::REG_FG: fg_r <= cfg_wdata;
        tcw_pkg::REG_BG: bg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tcw_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .init_done (init_done),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  tcw_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .ready      (q_ready),
    .pop        (q_pop),
    .head       (q_head),
    .valid      (q_valid)
  );

  tcw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .attr       ({bg_r, fg_r}),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .init_done  (init_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
